[sv/rmct_pkg.sv]
// shared types, constants and the node combine function of the range minimum tree
package rmct_pkg;

  localparam int SIZE_DEFAULT = 1024;
  localparam int VALUE_W = 33;
  localparam int COUNT_W = 11;
  localparam logic [VALUE_W-1:0] SENTINEL = {1'b1, 32'd0};

  localparam logic OP_SET = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] v;
    logic [COUNT_W-1:0] c;
  } node_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_CMB,
    ST_Q_LEFT,
    ST_Q_RIGHT,
    ST_Q_FIN
  } state_t;

  function automatic node_t combine(node_t a, node_t b);
    node_t r;
    if (a.v == b.v) begin
      r.v = a.v;
      r.c = a.c + b.c;
    end else if (a.v < b.v) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

[sv/range_min_with_count_tree.sv]
// range minimum with count: segment tree in one memory, walked by a small sequencer
//
// input channel (in_valid / in_stall) carries one word per operation: a set
// writes value at position and rebuilds the path to the root; a query over
// [range_left, range_right) returns min_value and min_count on the output
// channel (out_valid / out_stall). sets give no output word.
// every node access goes through one tree memory with one write port and one
// registered read port, and one shared combine unit.
// a set writes the leaf, then makes one read and one write per level up to the
// root. a query has two read slots per level, then a finish step.
// in_stall is high for the whole operation; a new word is taken once it is done.
// after reset a clearing pass writes every node to the sentinel with count one
// while in_stall is held high.
// a finished query result waits in the output register while out_stall is
// high; sets are still taken meanwhile, the next query holds in its finish step.
module range_min_with_count_tree #(
  parameter int SIZE = rmct_pkg::SIZE_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic [9:0]                  position,
  input  logic [31:0]                 value,
  input  logic [10:0]                 range_left,
  input  logic [10:0]                 range_right,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rmct_pkg::VALUE_W-1:0] min_value,
  output logic [rmct_pkg::COUNT_W-1:0] min_count
);

  localparam int LEVELS = $clog2(SIZE);
  localparam int SPAN = 1 << LEVELS;
  localparam int NODES = 2 * SPAN - 1;
  localparam int AW = LEVELS + 1;
  localparam int NW = LEVELS + 2;
  localparam int LW = $clog2(LEVELS + 2);
  localparam int PW = $clog2(2 * LEVELS + 4);
  localparam int CW = (AW > 11) ? AW : 11;

  rmct_pkg::state_t state, state_next;
  rmct_pkg::node_t  mem [NODES];
  rmct_pkg::node_t  rdata;
  rmct_pkg::node_t  cur, cur_next;
  rmct_pkg::node_t  cmb;
  rmct_pkg::node_t  wdata;

  logic [AW-1:0] node, node_next;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [NW-1:0] ql, ql_next, qr, qr_next, qr_dec;
  logic [AW-1:0] ls, ls_next, rs, rs_next;
  logic          lst, lst_next, rsticky, rsticky_next;
  logic [LW-1:0] lvl, lvl_next;
  logic [PW-1:0] parts, parts_next;
  logic          rd_pend, rd_pend_next;
  logic          out_valid_next;
  logic [rmct_pkg::VALUE_W-1:0] min_value_next;
  logic [rmct_pkg::COUNT_W-1:0] min_count_next;

  logic          accept;
  logic [CW-1:0] lx, rx, spanx, rc;
  logic          q_empty;
  logic          set_ok;
  logic [AW-1:0] leaf;
  logic [AW-1:0] parent;
  logic [AW-1:0] sibling;

  assign cmb = rmct_pkg::combine(cur, rdata);
  assign in_stall = (state != rmct_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;

  assign lx = CW'(range_left);
  assign rx = CW'(range_right);
  assign spanx = CW'(SPAN);
  assign rc = (rx > spanx) ? spanx : rx;
  assign q_empty = (lx >= rc);

  assign set_ok = ({22'd0, position} < 32'(SIZE));
  assign leaf = AW'(32'(SPAN - 1) + {22'd0, position});
  assign parent = AW'((node - AW'(1)) >> 1);
  assign sibling = node[0] ? AW'(node + AW'(1)) : AW'(node - AW'(1));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmct_pkg::ST_CLEAR;
      node <= '0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      node <= node_next;
      rd_pend <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    ql <= ql_next;
    qr <= qr_next;
    ls <= ls_next;
    rs <= rs_next;
    lst <= lst_next;
    rsticky <= rsticky_next;
    lvl <= lvl_next;
    parts <= parts_next;
    min_value <= min_value_next;
    min_count <= min_count_next;
  end

  always_comb begin
    state_next = state;
    node_next = node;
    cur_next = cur;
    ql_next = ql;
    qr_next = qr;
    qr_dec = qr;
    ls_next = ls;
    rs_next = rs;
    lst_next = lst;
    rsticky_next = rsticky;
    lvl_next = lvl;
    parts_next = parts;
    rd_pend_next = 1'b0;
    out_valid_next = out_valid && out_stall;
    min_value_next = min_value;
    min_count_next = min_count;
    raddr = '0;
    waddr = '0;
    wdata = cmb;
    we = 1'b0;

    case (state)
      rmct_pkg::ST_CLEAR: begin
        we = 1'b1;
        waddr = node;
        wdata.v = rmct_pkg::SENTINEL;
        wdata.c = rmct_pkg::COUNT_W'(1);
        node_next = AW'(node + AW'(1));
        if (node == AW'(NODES - 1)) begin
          state_next = rmct_pkg::ST_IDLE;
        end
      end
      rmct_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation == rmct_pkg::OP_SET) begin
            if (set_ok) begin
              we = 1'b1;
              waddr = leaf;
              wdata.v = {1'b0, value};
              wdata.c = rmct_pkg::COUNT_W'(1);
              cur_next.v = {1'b0, value};
              cur_next.c = rmct_pkg::COUNT_W'(1);
              node_next = leaf;
              if (leaf != '0) begin
                state_next = rmct_pkg::ST_SET_RD;
              end
            end
          end else begin
            ql_next = NW'(lx) + NW'(SPAN);
            qr_next = NW'(rc) + NW'(SPAN);
            ls_next = AW'(lx);
            rs_next = AW'(rc);
            lst_next = 1'b0;
            rsticky_next = 1'b0;
            lvl_next = '0;
            parts_next = '0;
            cur_next.v = rmct_pkg::SENTINEL;
            cur_next.c = '0;
            state_next = q_empty ? rmct_pkg::ST_Q_FIN : rmct_pkg::ST_Q_LEFT;
          end
        end
      end
      rmct_pkg::ST_SET_RD: begin
        raddr = sibling;
        state_next = rmct_pkg::ST_SET_CMB;
      end
      rmct_pkg::ST_SET_CMB: begin
        we = 1'b1;
        waddr = parent;
        wdata = cmb;
        cur_next = cmb;
        node_next = parent;
        state_next = (parent == '0) ? rmct_pkg::ST_IDLE : rmct_pkg::ST_SET_RD;
      end
      rmct_pkg::ST_Q_LEFT: begin
        if (rd_pend) begin
          cur_next = cmb;
        end
        if ((ql < qr) && ql[0]) begin
          raddr = AW'(ql - NW'(1));
          rd_pend_next = 1'b1;
          ql_next = NW'(ql + NW'(1));
        end
        state_next = rmct_pkg::ST_Q_RIGHT;
      end
      rmct_pkg::ST_Q_RIGHT: begin
        if (rd_pend) begin
          cur_next = cmb;
        end
        if ((ql < qr) && qr[0]) begin
          raddr = AW'(qr - NW'(2));
          rd_pend_next = 1'b1;
          qr_dec = NW'(qr - NW'(1));
        end
        ql_next = ql >> 1;
        qr_next = qr_dec >> 1;
        parts_next = PW'(parts + PW'(lst) + PW'(rsticky)
                     - PW'(lst && rsticky && (ls == rs)));
        lst_next = lst | ls[0];
        rsticky_next = rsticky | rs[0];
        ls_next = ls >> 1;
        rs_next = rs >> 1;
        lvl_next = LW'(lvl + LW'(1));
        state_next = (lvl == LW'(LEVELS)) ? rmct_pkg::ST_Q_FIN : rmct_pkg::ST_Q_LEFT;
      end
      rmct_pkg::ST_Q_FIN: begin
        if (rd_pend) begin
          cur_next = cmb;
        end else if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          min_value_next = cur.v;
          min_count_next = (cur.v == rmct_pkg::SENTINEL) ?
                           rmct_pkg::COUNT_W'(rmct_pkg::COUNT_W'(parts) + 1'b1) : cur.c;
          state_next = rmct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmct_pkg::ST_IDLE;
      end
    endcase
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == rmct_pkg::ST_Q_FIN)
    else $error("result word appeared outside the query finish step");

  a_clear_blocks: assert property (@(posedge clk)
    state == rmct_pkg::ST_CLEAR |-> in_stall)
    else $error("word taken during clearing pass");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> min_count != '0)
    else $error("result word with zero count");

  a_set_not_root: assert property (@(posedge clk) disable iff (rst)
    state == rmct_pkg::ST_SET_RD |-> node != '0)
    else $error("set path walked past the root");

  a_last_level: assert property (@(posedge clk) disable iff (rst)
    state == rmct_pkg::ST_Q_RIGHT && lvl == LW'(LEVELS) |=> state == rmct_pkg::ST_Q_FIN)
    else $error("query walk did not finish at the root level");

endmodule
